/* rtl/core/lkv_pkg.sv */
// Shared constants for the LRU key-value cache.
// Field widths, register map and operation codes; no dependencies.
package lkv_pkg;

  // Default sizing handed to the top-level parameters
  localparam int DEF_ENTRIES  = 16;
  localparam int DEF_KEY_BITS = 32;

  // Fixed widths of the transaction fields
  localparam int KEY_PORT_BITS = 32;
  localparam int DATA_BITS     = 32;

  // Configuration port: one 32-bit register at byte address 0
  localparam int PADDR_BITS  = 3;
  localparam int PDATA_BITS  = 32;
  localparam int REG_IDX_LSB = 2;
  localparam int REG_IDX_BITS = PADDR_BITS - REG_IDX_LSB;

  localparam logic [REG_IDX_BITS-1:0] REG_CAPACITY = REG_IDX_BITS'(0);

  // Capacity register
  localparam int                  CAP_BITS  = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

  // Operation codes of the kind field
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

endpackage

/* rtl/core/lru_key_value_cache.sv */
// Top level of the LRU key-value cache: capacity register and its APB port.
// Instantiates lkv_engine; uses lkv_pkg.
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  -----------------------------------------
//  request   req_valid / req_ready     kind, key, value
//  response  rsp_valid / rsp_ready     found, read_value, newest_key, newest_valid
//  config    psel/penable/pwrite/...   paddr, pwdata, prdata (capacity at 0x0)
//
//  An insert or a lookup hit makes two sweeps over the entries held between
//  acceptance and response: the first matches the key, the second re-ranks
//  entries; a lookup miss skips the second sweep.
//  Reset empties the store at once (entry count cleared), no clearing pass.
//  The response register holds a result under stall while the next request
//  transaction is accepted.
module lru_key_value_cache #(
  parameter int ENTRIES  = lkv_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = lkv_pkg::DEF_KEY_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lkv_pkg::PADDR_BITS-1:0]       paddr,
  input  logic [lkv_pkg::PDATA_BITS-1:0]       pwdata,
  output logic [lkv_pkg::PDATA_BITS-1:0]       prdata,
  output logic                                 pready,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  logic                                 kind,
  input  logic [lkv_pkg::KEY_PORT_BITS-1:0]    key,
  input  logic signed [lkv_pkg::DATA_BITS-1:0] value,
  output logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  output logic                                 found,
  output logic signed [lkv_pkg::DATA_BITS-1:0] read_value,
  output logic [lkv_pkg::KEY_PORT_BITS-1:0]    newest_key,
  output logic                                 newest_valid
);
  import lkv_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);

  logic [CAP_BITS-1:0]     capacity;
  logic [CW-1:0]           cap_eff;
  logic [REG_IDX_BITS-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_BITS-1:REG_IDX_LSB];

  // Write the capacity register on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_BITS-1:0];
    end
  end

  // Register read-back
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_CAPACITY) begin
      prdata = PDATA_BITS'(capacity);
    end
  end

  // Clamp capacity to the range one .. ENTRIES
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CW'(1);
    end else if (int'(capacity) > ENTRIES) begin
      cap_eff = CW'(ENTRIES);
    end else begin
      cap_eff = CW'(capacity);
    end
  end

  lkv_engine #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cap_eff      (cap_eff),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .kind         (kind),
    .key          (key),
    .value        (value),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .found        (found),
    .read_value   (read_value),
    .newest_key   (newest_key),
    .newest_valid (newest_valid)
  );

endmodule

/* rtl/core/lkv_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; contents are undefined until written.
module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/lkv_engine.sv */
// Lookup/insert sequencer for the LRU key-value cache.
// Sweeps the entry memory (lkv_ram) to match and re-rank; uses lkv_pkg.
module lkv_engine #(
  parameter int ENTRIES  = lkv_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = lkv_pkg::DEF_KEY_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [$clog2(ENTRIES+1)-1:0]        cap_eff,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic                                kind,
  input  logic [lkv_pkg::KEY_PORT_BITS-1:0]   key,
  input  logic signed [lkv_pkg::DATA_BITS-1:0] value,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic                                found,
  output logic signed [lkv_pkg::DATA_BITS-1:0] read_value,
  output logic [lkv_pkg::KEY_PORT_BITS-1:0]   newest_key,
  output logic                                newest_valid
);
  import lkv_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int KB = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;

  typedef struct packed {
    logic [KB-1:0]        key;
    logic [DATA_BITS-1:0] val;
    logic [IW-1:0]        rank;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UPDATE,
    S_RESULT
  } state_t;

  state_t state;

  // Captured transaction
  logic                 kind_r;
  logic [KB-1:0]        key_r;
  logic [DATA_BITS-1:0] val_r;

  // Store bookkeeping
  logic [CW-1:0] count;
  logic [KB-1:0] newest_r;

  // Sweep control: read issued at cnt_issue, data for idx_q arrives in the next cycle
  logic [CW-1:0] cnt_issue;
  logic          pend;
  logic [IW-1:0] idx_q;

  // Scan results
  logic                 hit;
  logic [IW-1:0]        hit_slot;
  logic [IW-1:0]        hit_rank;
  logic [DATA_BITS-1:0] hit_val;
  logic [IW-1:0]        old_slot;

  // Update plan
  logic [IW-1:0] slot;
  logic [CW-1:0] old_rank;
  logic          promote;
  logic          write_kv;

  // Pending result
  logic                 found_r;
  logic [DATA_BITS-1:0] rdv_r;

  // Memory ports
  entry_t        ent_rd;
  entry_t        ent_wr;
  logic          ram_we;
  logic [IW-1:0] ram_raddr;

  assign req_ready = (state == S_IDLE);
  assign ram_raddr = cnt_issue[IW-1:0];
  assign ram_we    = (state == S_UPDATE) && pend;

  // Re-rank or rewrite the entry coming back from the memory
  always_comb begin
    ent_wr = ent_rd;
    if (idx_q == slot) begin
      if (write_kv) begin
        ent_wr.key = key_r;
        ent_wr.val = val_r;
      end
      if (promote) begin
        ent_wr.rank = '0;
      end
    end else if (promote && (CW'(ent_rd.rank) < old_rank)) begin
      ent_wr.rank = ent_rd.rank + IW'(1);
    end
  end

  lkv_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_q),
    .wdata (ent_wr),
    .raddr (ram_raddr),
    .rdata (ent_rd)
  );

  // Sequencer, bookkeeping and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cnt_issue <= '0;
      pend      <= 1'b0;
      hit       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (state != S_RESULT)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            kind_r    <= kind;
            key_r     <= key[KB-1:0];
            val_r     <= $unsigned(value);
            hit       <= 1'b0;
            cnt_issue <= '0;
            pend      <= 1'b0;
            state     <= S_SCAN;
          end
        end

        // Match the key and locate the oldest entry
        S_SCAN: begin
          if (pend) begin
            if (!hit && (ent_rd.key == key_r)) begin
              hit      <= 1'b1;
              hit_slot <= idx_q;
              hit_rank <= ent_rd.rank;
              hit_val  <= ent_rd.val;
            end
            if (CW'(ent_rd.rank) == (count - CW'(1))) begin
              old_slot <= idx_q;
            end
          end
          if (cnt_issue < count) begin
            pend      <= 1'b1;
            idx_q     <= cnt_issue[IW-1:0];
            cnt_issue <= cnt_issue + CW'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_DECIDE;
            end
          end
        end

        // Pick the target slot and how ranks move
        S_DECIDE: begin
          cnt_issue <= '0;
          pend      <= 1'b0;
          if (kind_r == KIND_INSERT) begin
            write_kv <= 1'b1;
            found_r  <= 1'b0;
            rdv_r    <= '0;
            state    <= S_UPDATE;
            if (hit) begin
              slot     <= hit_slot;
              promote  <= 1'b0;
              old_rank <= '0;
            end else if (count < cap_eff) begin
              slot     <= count[IW-1:0];
              old_rank <= count + CW'(1);
              count    <= count + CW'(1);
              promote  <= 1'b1;
              newest_r <= key_r;
            end else begin
              slot     <= old_slot;
              old_rank <= count - CW'(1);
              promote  <= 1'b1;
              newest_r <= key_r;
            end
          end else begin
            write_kv <= 1'b0;
            slot     <= hit_slot;
            old_rank <= CW'(hit_rank);
            promote  <= hit;
            found_r  <= hit;
            rdv_r    <= hit ? hit_val : '0;
            if (hit) begin
              newest_r <= key_r;
              state    <= S_UPDATE;
            end else begin
              state <= S_RESULT;
            end
          end
        end

        // Read-modify-write every held entry
        S_UPDATE: begin
          if (cnt_issue < count) begin
            pend      <= 1'b1;
            idx_q     <= cnt_issue[IW-1:0];
            cnt_issue <= cnt_issue + CW'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_RESULT;
            end
          end
        end

        // Hold until the result register is free
        S_RESULT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid    <= 1'b1;
            found        <= found_r;
            read_value   <= $signed(rdv_r);
            newest_key   <= (count != '0) ? KEY_PORT_BITS'(newest_r) : '0;
            newest_valid <= (count != '0);
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* bench/lru_key_value_cache_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for lru_key_value_cache: directed and random traffic.
// A built-in LRU predictor checks every response; depends on lkv_pkg and the RTL.
module lru_key_value_cache_test;
  import lkv_pkg::*;

  localparam int ENTRIES      = DEF_ENTRIES;
  localparam int DRAIN_CYCLES = 2 * ENTRIES + 6;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int POOL_MAX     = 24;
  localparam int PRINT_MAX    = 50;

  localparam logic [PADDR_BITS-1:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
  localparam logic [PADDR_BITS-1:0] ADDR_UNUSED   = {~REG_CAPACITY, 2'b00};

  localparam logic [31:0] KEY_ZERO  = 32'h0000_0000;
  localparam logic [31:0] KEY_ONES  = 32'hFFFF_FFFF;
  localparam logic [31:0] KEY_MIXED = 32'hA5A5_5A5A;

  typedef struct packed {
    logic                        found;
    logic signed [DATA_BITS-1:0] read_value;
    logic [KEY_PORT_BITS-1:0]    newest_key;
    logic                        newest_valid;
  } cache_result_t;

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [PDATA_BITS-1:0] pwdata = '0;
  logic [PDATA_BITS-1:0] prdata;
  logic pready;
  logic req_valid = 1'b0;
  logic req_ready;
  logic kind = KIND_INSERT;
  logic [KEY_PORT_BITS-1:0] key = '0;
  logic signed [DATA_BITS-1:0] value = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  logic found;
  logic signed [DATA_BITS-1:0] read_value;
  logic [KEY_PORT_BITS-1:0] newest_key;
  logic newest_valid;

  // Predictor state
  logic [KEY_PORT_BITS-1:0] cache_keys[ENTRIES];
  logic [DATA_BITS-1:0]     cache_values[ENTRIES];
  int unsigned              cache_age[ENTRIES];
  int unsigned              cache_count = 0;
  logic [CAP_BITS-1:0]      capacity_reg = CAP_RESET;

  cache_result_t expected_responses[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int mismatch_count = 0;
  int response_count = 0;
  int stall_cycles = 0;

  lru_key_value_cache uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_ready(req_ready),
    .kind(kind), .key(key), .value(value),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .found(found), .read_value(read_value),
    .newest_key(newest_key), .newest_valid(newest_valid)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Make slot s most recent; entries younger than its old age grow one older
  function automatic void promote_entry(input int s, input int unsigned old_age);
    int i;
    for (i = 0; i < int'(cache_count); i++) begin
      if (i != s && cache_age[i] < old_age) cache_age[i]++;
    end
    cache_age[s] = 0;
  endfunction

  // Apply one access to the predictor and return the response it causes
  function automatic cache_result_t predict_access(input logic op,
                                                   input logic [KEY_PORT_BITS-1:0] k,
                                                   input logic [DATA_BITS-1:0] v);
    cache_result_t r;
    int slot;
    int i;
    int unsigned limit;
    int unsigned old_age;
    r = '0;
    slot = -1;
    for (i = 0; i < int'(cache_count); i++) begin
      if (slot < 0 && cache_keys[i] == k) slot = i;
    end
    if (op == KIND_INSERT) begin
      if (slot >= 0) begin
        cache_values[slot] = v;
      end else begin
        limit = (capacity_reg == 0) ? 1 : (capacity_reg > ENTRIES ? ENTRIES : capacity_reg);
        if (cache_count < limit) begin
          slot = cache_count;
          cache_count++;
          old_age = cache_count;
        end else begin
          slot = 0;
          for (i = 1; i < int'(cache_count); i++) begin
            if (cache_age[i] > cache_age[slot]) slot = i;
          end
          old_age = cache_age[slot];
        end
        cache_keys[slot] = k;
        cache_values[slot] = v;
        promote_entry(slot, old_age);
      end
    end else if (slot >= 0) begin
      r.found = 1'b1;
      r.read_value = cache_values[slot];
      promote_entry(slot, cache_age[slot]);
    end
    for (i = 0; i < int'(cache_count); i++) begin
      if (cache_age[i] == 0) r.newest_key = cache_keys[i];
    end
    r.newest_valid = (cache_count > 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_MAX)
      $display("[%0t] mismatch on %s at response %0d: got %h, expected %h",
               $realtime, what, response_count, got, want);
  endtask

  // Send one request transaction; predict its response once accepted
  task automatic send_item(input logic op, input logic [KEY_PORT_BITS-1:0] k,
                           input logic [DATA_BITS-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    kind <= op;
    key <= k;
    value <= v;
    do @(posedge clk); while (!req_ready);
    expected_responses.push_back(predict_access(op, k, v));
  endtask

  // Drop valid, wait for every response, then let the engine settle
  task automatic drain_pipeline();
    req_valid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_BITS-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[PADDR_BITS-1:REG_IDX_LSB] == REG_CAPACITY) capacity_reg = data[CAP_BITS-1:0];
  endtask

  task automatic set_capacity(input logic [31:0] cap);
    drain_pipeline();
    apb_write(ADDR_CAPACITY, cap);
  endtask

  // Empty store: a lookup misses and reports no newest entry; then the key is inserted
  task automatic test_empty_store();
    send_item(KIND_LOOKUP, 32'h1234_5678, 32'h0);
    send_item(KIND_INSERT, 32'h1234_5678, 32'h0);
  endtask

  // Extreme keys and values, lookup hits and promotion
  task automatic test_field_extremes();
    send_item(KIND_INSERT, KEY_ZERO, 32'h8000_0000);
    send_item(KIND_INSERT, KEY_ONES, 32'h7FFF_FFFF);
    send_item(KIND_INSERT, KEY_MIXED, 32'hFFFF_FFFF);
    send_item(KIND_LOOKUP, KEY_ZERO, 32'hFFFF_FFFF);
    send_item(KIND_LOOKUP, KEY_ONES, 32'h0);
  endtask

  // Overwrite keeps recency; a miss changes nothing
  task automatic test_update_and_miss();
    send_item(KIND_INSERT, KEY_ZERO, 32'h0);
    send_item(KIND_LOOKUP, KEY_ZERO, 32'h0);
    send_item(KIND_LOOKUP, 32'hDEAD_BEEF, 32'h5555_5555);
  endtask

  // Capacity below the count, zero, saturated, and a write to an unused address
  task automatic test_capacity_limits();
    set_capacity(2);
    send_item(KIND_INSERT, 32'h0000_0101, 32'h1);
    send_item(KIND_LOOKUP, 32'h1234_5678, 32'h0);
    send_item(KIND_LOOKUP, KEY_MIXED, 32'h0);
    set_capacity(0);
    send_item(KIND_INSERT, 32'h0000_0202, 32'h2);
    send_item(KIND_LOOKUP, KEY_ONES, 32'h0);
    set_capacity(31);
    send_item(KIND_INSERT, 32'h0000_0303, 32'h3);
    set_capacity(3);
    @(posedge clk);
    apb_write(ADDR_UNUSED, 32'd16);
    send_item(KIND_INSERT, 32'h0000_0404, 32'h4);
    send_item(KIND_LOOKUP, 32'h0000_0202, 32'h0);
    set_capacity(1);
    send_item(KIND_INSERT, 32'h0000_0505, 32'h5);
    send_item(KIND_LOOKUP, 32'h0000_0505, 32'h0);
  endtask

  // Random accesses over a small key pool so hits and evictions are frequent
  task automatic test_random_traffic(input int count, input logic [31:0] cap);
    logic [KEY_PORT_BITS-1:0] key_pool[POOL_MAX];
    int pool_size;
    int n;
    logic [KEY_PORT_BITS-1:0] k;
    set_capacity(cap);
    pool_size = $urandom_range(POOL_MAX, 2);
    for (n = 0; n < POOL_MAX; n++) begin
      case ($urandom_range(7))
        0: key_pool[n] = KEY_ZERO;
        1: key_pool[n] = KEY_ONES;
        default: key_pool[n] = $urandom();
      endcase
    end
    for (n = 0; n < count; n++) begin
      k = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(pool_size - 1)];
      send_item(1'($urandom_range(1)), k, $urandom());
    end
  endtask

  // Hold the response side off while requests keep coming
  task automatic test_backpressure();
    int n;
    set_capacity(6);
    hold_request = 1'b1;
    for (n = 0; n < 40; n++)
      send_item(1'($urandom_range(1)), $urandom_range(7), $urandom());
  endtask

  // Response side: drive ready, check each response against the oldest prediction
  always @(posedge clk) begin : check_responses
    cache_result_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      response_count++;
      if (expected_responses.size() == 0) begin
        report_mismatch("unexpected response", newest_key, 32'h0);
      end else begin
        want = expected_responses.pop_front();
        if (found !== want.found) report_mismatch("found", 32'(found), 32'(want.found));
        if (read_value !== want.read_value)
          report_mismatch("read_value", read_value, want.read_value);
        if (newest_key !== want.newest_key)
          report_mismatch("newest_key", newest_key, want.newest_key);
        if (newest_valid !== want.newest_valid)
          report_mismatch("newest_valid", 32'(newest_valid), 32'(want.newest_valid));
      end
    end
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run when nothing is accepted for too long
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** lru_key_value_cache: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 38;
    recv_idle_pct = 88;
    test_empty_store();
    test_field_extremes();
    test_update_and_miss();
    test_capacity_limits();
    test_random_traffic(250, 16);
    test_random_traffic(250, 3);

    send_idle_pct = 88;
    recv_idle_pct = 38;
    test_random_traffic(250, 31);
    test_random_traffic(250, 1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(250, 8);
    test_backpressure();
    test_random_traffic(150, 0);
    test_random_traffic(100, 16);

    drain_pipeline();
    if (expected_responses.size() != 0)
      report_mismatch("missing responses", 32'(expected_responses.size()), 32'h0);
    if (mismatch_count == 0) begin
      $display("** lru_key_value_cache: PASSED **");
    end else begin
      $display("** lru_key_value_cache: FAILED **");
    end
    $finish;
  end

endmodule
